>>> hw/rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants for the triangle unit normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

  localparam int unsigned CoordWidthDef = 24;
  localparam int unsigned UnitFracDef   = 14;
  localparam int unsigned OutWidth      = 16;

endpackage

`default_nettype wire

>>> hw/rtl/tun_if.sv
// ----------------------------------------------------------------------------
// tun_tri_if / tun_nrm_if
// Valid/ready channels for triangle beats in and normal beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tun_tri_if #(
  parameter int unsigned CW = 24
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] ax, ay, az;
  logic signed [CW-1:0] bx, by, bz;
  logic signed [CW-1:0] cx, cy, cz;

  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_nrm_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] nx, ny, nz;
  logic        degenerate;

  modport source (output valid, nx, ny, nz, degenerate, input ready);
  modport sink   (input valid, nx, ny, nz, degenerate, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tun_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tun_sqrt_cell
// One digit of a restoring square root: resolves one root bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_sqrt_cell #(
  parameter  int unsigned SW = 52,
  parameter  int unsigned PW = 1,
  localparam int unsigned RW = SW / 2
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [SW-1:0] val_i,
  input  wire logic [RW+1:0] rem_i,
  input  wire logic [RW-1:0] root_i,
  input  wire logic [PW-1:0] pay_i,
  output logic      [SW-1:0] val_o,
  output logic      [RW+1:0] rem_o,
  output logic      [RW-1:0] root_o,
  output logic      [PW-1:0] pay_o
);

  logic [RW+1:0] rem_sh, trial, rem_d;
  logic          ge;

  always_comb begin
    rem_sh = {rem_i[RW-1:0], val_i[SW-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_o  <= {val_i[SW-3:0], 2'b00};
      rem_o  <= rem_d;
      root_o <= {root_i[RW-2:0], ge};
      pay_o  <= pay_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tun_div_cell.sv
// ----------------------------------------------------------------------------
// tun_div_cell
// One step of a restoring divider: resolves one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_div_cell #(
  parameter int unsigned LW    = 26,
  parameter int unsigned QW    = 15,
  parameter bit          FIRST = 1'b0
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [LW:0]   r_i,
  input  wire logic [LW-1:0] len_i,
  input  wire logic [QW-1:0] q_i,
  input  wire logic          sgn_i,
  output logic      [LW:0]   r_o,
  output logic      [LW-1:0] len_o,
  output logic      [QW-1:0] q_o,
  output logic               sgn_o
);

  logic [LW:0] rs, r_d;
  logic        ge;

  always_comb begin
    // the first step sees the bare dividend; later steps bring down a zero
    rs  = FIRST ? r_i : {r_i[LW-1:0], 1'b0};
    ge  = (rs >= {1'b0, len_i});
    r_d = ge ? (rs - {1'b0, len_i}) : rs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o   <= r_d;
      len_o <= len_i;
      q_o   <= {q_i[QW-2:0], ge};
      sgn_o <= sgn_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tun_unitize.sv
// ----------------------------------------------------------------------------
// tun_unitize
// Scales a 3-vector to unit length: square, sum, root chain, divider chains.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_unitize #(
  parameter  int unsigned VW   = 25,
  parameter  int unsigned FRAC = 14,
  localparam int unsigned UW   = FRAC + 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [VW-1:0] v_i [3],
  output logic                      valid_o,
  output logic signed [UW-1:0]      u_o [3],
  output logic                      zero_o
);

  localparam int unsigned MW    = VW;
  localparam int unsigned SW    = 2 * MW + 2;
  localparam int unsigned RW    = SW / 2;
  localparam int unsigned QW    = FRAC + 1;
  localparam int unsigned PW    = 3 * MW + 3;
  localparam int unsigned DEPTH = 2 + RW + QW;

  // valid line over the whole unit
  logic [DEPTH-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DEPTH-2:0], valid_i};
    end
  end
  assign valid_o = vld_q[DEPTH-1];

  // square stage
  logic [MW-1:0]   mag_a_q [3];
  logic            sgn_a_q [3];
  logic [2*MW-1:0] sq_a_q  [3];
  logic [MW-1:0]   mag_d   [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag_d[j] = v_i[j][VW-1] ? MW'(-v_i[j]) : MW'(v_i[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        mag_a_q[j] <= mag_d[j];
        sgn_a_q[j] <= v_i[j][VW-1];
        sq_a_q[j]  <= {{MW{1'b0}}, mag_d[j]} * {{MW{1'b0}}, mag_d[j]};
      end
    end
  end

  // sum stage
  logic [SW-1:0] sum_b_q;
  logic [PW-1:0] pay_b_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_b_q <= SW'(sq_a_q[0]) + SW'(sq_a_q[1]) + SW'(sq_a_q[2]);
      pay_b_q <= {sgn_a_q[2], sgn_a_q[1], sgn_a_q[0], mag_a_q[2], mag_a_q[1], mag_a_q[0]};
    end
  end

  // root chain
  logic [SW-1:0] val_c  [RW+1];
  logic [RW+1:0] rem_c  [RW+1];
  logic [RW-1:0] root_c [RW+1];
  logic [PW-1:0] pay_c  [RW+1];

  assign val_c[0]  = sum_b_q;
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  assign pay_c[0]  = pay_b_q;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    tun_sqrt_cell #(.SW(SW), .PW(PW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .val_i  (val_c[k]),
      .rem_i  (rem_c[k]),
      .root_i (root_c[k]),
      .pay_i  (pay_c[k]),
      .val_o  (val_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .root_o (root_c[k+1]),
      .pay_o  (pay_c[k+1])
    );
  end

  // a zero length divides by one
  logic [RW-1:0] len0;
  logic          zero0;
  assign zero0 = (root_c[RW] == '0);
  assign len0  = zero0 ? RW'(1) : root_c[RW];

  logic [QW-1:0] zero_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= {zero_q[QW-2:0], zero0};
    end
  end
  assign zero_o = zero_q[QW-1];

  // divider chains, one per component
  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic [RW:0]   r_c   [QW+1];
    logic [RW-1:0] len_c [QW+1];
    logic [QW-1:0] q_c   [QW+1];
    logic          sgn_c [QW+1];

    assign r_c[0]   = (RW+1)'(pay_c[RW][j*MW +: MW]);
    assign len_c[0] = len0;
    assign q_c[0]   = '0;
    assign sgn_c[0] = pay_c[RW][3*MW + j];

    for (genvar k = 0; k < QW; k++) begin : g_div
      tun_div_cell #(.LW(RW), .QW(QW), .FIRST(k == 0)) u_cell (
        .clk_i (clk_i),
        .en_i  (en_i),
        .r_i   (r_c[k]),
        .len_i (len_c[k]),
        .q_i   (q_c[k]),
        .sgn_i (sgn_c[k]),
        .r_o   (r_c[k+1]),
        .len_o (len_c[k+1]),
        .q_o   (q_c[k+1]),
        .sgn_o (sgn_c[k+1])
      );
    end

    assign u_o[j] = sgn_c[QW] ? -$signed(UW'(q_c[QW])) : $signed(UW'(q_c[QW]));
  end

endmodule

`default_nettype wire

>>> hw/rtl/triangle_unit_normal_unit.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_unit
// Unit face normal of a triangle in Q1.UNIT_FRAC_BITS fixed point.
// ----------------------------------------------------------------------------
// Takes one triangle beat per cycle and returns one normal beat per triangle,
// in order. The datapath is a fixed pipeline: edge subtract, a unit-scaling
// chain for both edges, a cross-product multiply and subtract, a second
// unit-scaling chain, and an output register. Each scaling chain is one
// square stage, one sum stage, a row of root cells (one root bit per cell,
// VW+1 cells for a VW-bit vector) and a row of divider cells
// (UNIT_FRAC_BITS+1 cells). The edges are COORD_WIDTH+1 bits wide and the
// cross product 2*UNIT_FRAC_BITS+5 bits.
// The whole pipeline advances whenever the output register is free or being
// taken, so the sustained rate is one triangle per cycle.
`default_nettype none

module triangle_unit_normal_unit #(
  parameter int unsigned COORD_WIDTH    = tun_pkg::CoordWidthDef,
  parameter int unsigned UNIT_FRAC_BITS = tun_pkg::UnitFracDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tun_tri_if.sink   tri_i,
  tun_nrm_if.source nrm_o
);
  import tun_pkg::*;

  localparam int unsigned EW = COORD_WIDTH + 1;
  localparam int unsigned UW = UNIT_FRAC_BITS + 2;
  localparam int unsigned PW = 2 * UW;
  localparam int unsigned CW = PW + 1;

  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || nrm_o.ready;
  assign tri_i.ready = en;

  // edge stage
  logic                 e_valid_q;
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= tri_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q[0] <= EW'(tri_i.bx) - EW'(tri_i.ax);
      e1_q[1] <= EW'(tri_i.by) - EW'(tri_i.ay);
      e1_q[2] <= EW'(tri_i.bz) - EW'(tri_i.az);
      e2_q[0] <= EW'(tri_i.cx) - EW'(tri_i.ax);
      e2_q[1] <= EW'(tri_i.cy) - EW'(tri_i.ay);
      e2_q[2] <= EW'(tri_i.cz) - EW'(tri_i.az);
    end
  end

  // unit edges
  logic                 u_valid;
  logic signed [UW-1:0] u1 [3];
  logic signed [UW-1:0] u2 [3];

  tun_unitize #(.VW(EW), .FRAC(UNIT_FRAC_BITS)) u_edge1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_valid_q),
    .v_i     (e1_q),
    .valid_o (u_valid),
    .u_o     (u1),
    .zero_o  ()
  );

  tun_unitize #(.VW(EW), .FRAC(UNIT_FRAC_BITS)) u_edge2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_valid_q),
    .v_i     (e2_q),
    .valid_o (),
    .u_o     (u2),
    .zero_o  ()
  );

  // cross product: products, then differences
  logic                 m_valid_q, x_valid_q;
  logic signed [PW-1:0] p_q [6];
  logic signed [CW-1:0] x_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      x_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= u_valid;
      x_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= u1[1] * u2[2];
      p_q[1] <= u1[2] * u2[1];
      p_q[2] <= u1[2] * u2[0];
      p_q[3] <= u1[0] * u2[2];
      p_q[4] <= u1[0] * u2[1];
      p_q[5] <= u1[1] * u2[0];
      x_q[0] <= CW'(p_q[0]) - CW'(p_q[1]);
      x_q[1] <= CW'(p_q[2]) - CW'(p_q[3]);
      x_q[2] <= CW'(p_q[4]) - CW'(p_q[5]);
    end
  end

  // unit normal
  logic                 n_valid, n_zero;
  logic signed [UW-1:0] n [3];

  tun_unitize #(.VW(CW), .FRAC(UNIT_FRAC_BITS)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (x_valid_q),
    .v_i     (x_q),
    .valid_o (n_valid),
    .u_o     (n),
    .zero_o  (n_zero)
  );

  // output register
  logic signed [OutWidth-1:0] nx_q, ny_q, nz_q;
  logic                       degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= n_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q    <= OutWidth'(n[0]);
      ny_q    <= OutWidth'(n[1]);
      nz_q    <= OutWidth'(n[2]);
      degen_q <= n_zero;
    end
  end

  assign nrm_o.valid      = out_valid_q;
  assign nrm_o.nx         = nx_q;
  assign nrm_o.ny         = ny_q;
  assign nrm_o.nz         = nz_q;
  assign nrm_o.degenerate = degen_q;

`ifndef SYNTHESIS
  localparam logic signed [OutWidth-1:0] One = OutWidth'(1 << UNIT_FRAC_BITS);

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && degen_q |-> nx_q == 0 && ny_q == 0 && nz_q == 0)
    else $error("degenerate beat carries a nonzero normal");

  a_nondegen_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !degen_q |-> nx_q != 0 || ny_q != 0 || nz_q != 0)
    else $error("non-degenerate beat carries a zero normal");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> nx_q <= One && nx_q >= -One && ny_q <= One && ny_q >= -One
                    && nz_q <= One && nz_q >= -One)
    else $error("normal component beyond unit range");
`endif

endmodule

`default_nettype wire
